// File: hw/rtl/rfar_pkg.sv
// ----------------------------------------------------------------------------
// rfar_pkg: shared types and constants for the ASCII RFID frame receiver
// Frame layout constants, event and item codes, queue entry and config types.
// ----------------------------------------------------------------------------
package rfar_pkg;

   // Field and register widths
   localparam int CFG_WIDTH          = 16;
   localparam int TAG_WIDTH          = 40;
   localparam int COUNT_WIDTH        = 32;
   localparam int TIME_WIDTH_DEFAULT = 16;
   localparam int CSR_INDEX_WIDTH    = 2;

   // Register reset values
   localparam logic [CFG_WIDTH-1:0] DUP_WINDOW_RESET    = 16'd2000;
   localparam logic [CFG_WIDTH-1:0] PRESENCE_HOLD_RESET = 16'd3000;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DUP_WINDOW    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESENCE_HOLD = 2'd1;

   // Frame layout
   localparam logic [3:0] FRAME_LEN  = 4'd14;
   localparam logic [3:0] LAST_POS   = 4'd13;
   localparam logic [3:0] LAST_DIGIT = 4'd10;   // last tag digit position
   localparam logic [7:0] START_BYTE = 8'h02;
   localparam logic [7:0] END_BYTE   = 8'h03;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Result event codes
   typedef enum logic [1:0] {
      EV_NONE      = 2'd0,
      EV_ACCEPTED  = 2'd1,
      EV_DUPLICATE = 2'd2,
      EV_INVALID   = 2'd3
   } event_type;

   // Classified item kinds handed from front to back
   typedef enum logic [1:0] {
      KIND_TICK = 2'd0,
      KIND_BYTE = 2'd1,
      KIND_GOOD = 2'd2,
      KIND_BAD  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [TAG_WIDTH-1:0]   tag;
   } entry_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] dup_window;
      logic [CFG_WIDTH-1:0] presence_hold;
   } cfg_type;

   // ASCII hex digit decode: {valid, nibble}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/rfar_front.sv
// ----------------------------------------------------------------------------
// rfar_front: byte gathering and frame checking
// Tracks frame position, checks digits and checksum byte by byte, and emits
// one classified entry per transfer.
// ----------------------------------------------------------------------------
module rfar_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                mode,
   input  logic [7:0]          rx_byte,
   output rfar_pkg::entry_type entry
);
   import rfar_pkg::*;

   logic [3:0]           pos_ff, pos_in;
   logic                 ok_ff, ok_in;
   logic [3:0]           xor_hi_ff, xor_hi_in;
   logic [3:0]           xor_lo_ff, xor_lo_in;
   logic [TAG_WIDTH-1:0] tag_ff, tag_in;
   logic [3:0]           p;
   logic [4:0]           hex;
   logic                 good;

   // Position of this byte after restart handling
   always_comb begin
      p   = pos_ff;
      if (rx_byte == START_BYTE || pos_ff >= FRAME_LEN) begin
         p = 4'd0;
      end
      hex = hex_decode(rx_byte);
   end

   // Per-byte checks and classification
   always_comb begin
      pos_in     = pos_ff;
      ok_in      = ok_ff;
      xor_hi_in  = xor_hi_ff;
      xor_lo_in  = xor_lo_ff;
      tag_in     = tag_ff;
      good       = ok_ff && rx_byte == END_BYTE && xor_hi_ff == 4'd0 && xor_lo_ff == 4'd0;
      entry.kind = KIND_TICK;
      entry.tag  = tag_ff;
      if (!mode) begin
         entry.kind = KIND_BYTE;
         pos_in     = p + 4'd1;
         priority if (p == 4'd0) begin
            ok_in     = (rx_byte == START_BYTE);
            xor_hi_in = 4'd0;
            xor_lo_in = 4'd0;
         end else if (p == LAST_POS) begin
            pos_in     = 4'd0;
            entry.kind = good ? KIND_GOOD : KIND_BAD;
         end else begin
            ok_in = ok_ff & hex[4];
            if (p[0]) begin
               xor_hi_in = xor_hi_ff ^ hex[3:0];
            end else begin
               xor_lo_in = xor_lo_ff ^ hex[3:0];
            end
            if (p <= LAST_DIGIT) begin
               tag_in = {tag_ff[TAG_WIDTH-5:0], hex[3:0]};
            end
         end
      end
   end

   // Frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 4'd0;
         ok_ff  <= 1'b0;
      end else if (accept) begin
         pos_ff <= pos_in;
         ok_ff  <= ok_in;
      end
   end

   // Accumulators, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         xor_hi_ff <= xor_hi_in;
         xor_lo_ff <= xor_lo_in;
         tag_ff    <= tag_in;
      end
   end

endmodule

// File: hw/rtl/rfar_queue.sv
// ----------------------------------------------------------------------------
// rfar_queue: small FIFO between front and back
// Four entries; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module rfar_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rfar_pkg::entry_type push_data,
   output logic                full,
   output logic                not_empty,
   input  logic                pop,
   output rfar_pkg::entry_type pop_data
);
   import rfar_pkg::*;

   localparam int PtrWidth = $clog2(QUEUE_DEPTH);

   entry_type             mem_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PtrWidth:0]     count_ff, count_in;

   assign full      = (count_ff == (PtrWidth+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/rfar_back.sv
// ----------------------------------------------------------------------------
// rfar_back: tag bookkeeping and result register
// Applies duplicate suppression, elapsed time, presence and read count, and
// holds one result for the output channel.
// ----------------------------------------------------------------------------
module rfar_back #(
   parameter int TIME_WIDTH = rfar_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rfar_pkg::cfg_type                 cfg,
   input  logic                              q_valid,
   input  rfar_pkg::entry_type               q_data,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_event_code,
   output logic [rfar_pkg::TAG_WIDTH-1:0]    rsp_tag_id,
   output logic                              rsp_tag_present,
   output logic [rfar_pkg::COUNT_WIDTH-1:0]  rsp_read_count
);
   import rfar_pkg::*;

   localparam int CmpWidth = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;

   logic [TAG_WIDTH-1:0]   last_tag_ff, last_tag_in;
   logic                   last_valid_ff, last_valid_in;
   logic [TIME_WIDTH-1:0]  ticks_ff, ticks_in;
   logic                   present_ff, present_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   event_type              event_in;
   logic                   out_valid_ff;
   event_type              event_ff;
   logic                   dup;

   // Take an entry when the result register is free or being drained
   assign q_pop = q_valid && (!out_valid_ff || !rsp_stall);

   // Bookkeeping for one entry
   always_comb begin
      last_tag_in   = last_tag_ff;
      last_valid_in = last_valid_ff;
      ticks_in      = ticks_ff;
      present_in    = present_ff;
      count_in      = count_ff;
      event_in      = EV_NONE;
      dup = last_valid_ff && q_data.tag == last_tag_ff &&
            CmpWidth'(ticks_ff) < CmpWidth'(cfg.dup_window);
      unique case (q_data.kind)
         KIND_TICK: begin
            if (ticks_ff != '1) ticks_in = ticks_ff + 1'b1;
         end
         KIND_BYTE: begin
            event_in = EV_NONE;
         end
         KIND_GOOD: begin
            present_in = 1'b1;
            if (dup) begin
               event_in = EV_DUPLICATE;
            end else begin
               event_in      = EV_ACCEPTED;
               last_tag_in   = q_data.tag;
               last_valid_in = 1'b1;
               ticks_in      = '0;
               count_in      = count_ff + 1'b1;
            end
         end
         KIND_BAD: begin
            event_in = EV_INVALID;
         end
         default: event_in = EV_NONE;
      endcase
      // Presence times out past the hold
      if (CmpWidth'(ticks_in) > CmpWidth'(cfg.presence_hold)) present_in = 1'b0;
   end

   // State and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         last_tag_ff   <= '0;
         last_valid_ff <= 1'b0;
         ticks_ff      <= '1;
         present_ff    <= 1'b0;
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (q_pop) begin
            last_tag_ff   <= last_tag_in;
            last_valid_ff <= last_valid_in;
            ticks_ff      <= ticks_in;
            present_ff    <= present_in;
            count_ff      <= count_in;
            out_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff  <= 1'b0;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         event_ff <= event_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_event_code  = event_ff;
   assign rsp_tag_id      = last_tag_ff;
   assign rsp_tag_present = present_ff;
   assign rsp_read_count  = count_ff;

endmodule

// File: hw/rtl/rfid_ascii_frame_receiver.sv
// ----------------------------------------------------------------------------
// rfid_ascii_frame_receiver: ASCII serial RFID frame receiver
// Gathers 14-byte frames, checks them, reports tag reads with duplicate
// suppression and presence tracking; millisecond ticks advance elapsed time.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-------------------------------------
//   req     | in  | req_valid/stall    | mode, rx_byte
//   rsp     | out | rsp_valid/stall    | event_code, tag_id, tag_present,
//           |     |                    | read_count
//   csr     | in  | csr_valid/ready    | csr_index, csr_wdata
//
// One transfer per cycle on req while req_stall is low; each item gives one rsp result.
// The front is combinational; the queue registers each req transfer and the
// back's result register follows, so rsp_valid rises from that register once
// the back takes the entry from the queue, which waits while a result stalls.
// req_stall rises only when the queue is full, i.e. after rsp stalls long
// enough to fill it; csr_ready is always high.
// Reset is synchronous: frame position, tag history, read count and queue
// clear, elapsed time goes to saturated, registers return to defaults.
// ----------------------------------------------------------------------------
module rfid_ascii_frame_receiver #(
   parameter int TIME_WIDTH = rfar_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_mode,
   input  logic [7:0]                            req_rx_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_event_code,
   output logic [rfar_pkg::TAG_WIDTH-1:0]        rsp_tag_id,
   output logic                                  rsp_tag_present,
   output logic [rfar_pkg::COUNT_WIDTH-1:0]      rsp_read_count,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rfar_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [rfar_pkg::CFG_WIDTH-1:0]        csr_wdata
);
   import rfar_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   entry_type front_entry;
   entry_type q_data;
   logic      q_full, q_valid, q_pop;
   logic      req_accept;

   assign csr_ready  = 1'b1;
   assign req_stall  = q_full;
   assign req_accept = req_valid && !q_full;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         if (csr_index == CSR_DUP_WINDOW)    cfg_in.dup_window    = csr_wdata;
         if (csr_index == CSR_PRESENCE_HOLD) cfg_in.presence_hold = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dup_window    <= DUP_WINDOW_RESET;
         cfg_ff.presence_hold <= PRESENCE_HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rfar_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .mode    (req_mode),
      .rx_byte (req_rx_byte),
      .entry   (front_entry)
   );

   rfar_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_entry),
      .full      (q_full),
      .not_empty (q_valid),
      .pop       (q_pop),
      .pop_data  (q_data)
   );

   rfar_back #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_valid         (q_valid),
      .q_data          (q_data),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_code  (rsp_event_code),
      .rsp_tag_id      (rsp_tag_id),
      .rsp_tag_present (rsp_tag_present),
      .rsp_read_count  (rsp_read_count)
   );

endmodule

// File: hw/rtl/rfar_checker.sv
// ----------------------------------------------------------------------------
// rfar_checker: port-level checks for the frame receiver
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
module rfar_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [1:0]                            rsp_event_code,
   input logic [rfar_pkg::TAG_WIDTH-1:0]        rsp_tag_id,
   input logic                                  rsp_tag_present,
   input logic [rfar_pkg::COUNT_WIDTH-1:0]      rsp_read_count
);
   import rfar_pkg::*;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_code) &&
         $stable(rsp_tag_id) && $stable(rsp_tag_present) && $stable(rsp_read_count))
      else $error("rsp payload changed while stalled");

   // A fresh read restarts elapsed time, so presence is set
   a_accept_present: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_code == EV_ACCEPTED |-> rsp_tag_present)
      else $error("accepted tag without presence");

   // Reset empties the pipeline and the queue
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind rfid_ascii_frame_receiver rfar_checker u_rfar_checker (.*);

// File: tb/sv/rfid_ascii_frame_receiver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rfid_ascii_frame_receiver_tb: self-checking bench for the ASCII RFID receiver
// Sends serial bytes and millisecond ticks, keeps its own copy of the frame,
// tag history and timer state, and compares every status transfer field by
// field under random sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module rfid_ascii_frame_receiver_tb;
   import rfar_pkg::*;

   localparam int              TW           = TIME_WIDTH_DEFAULT;
   localparam logic [TW-1:0]   ELAPSED_MAX  = '1;
   localparam logic            MODE_BYTE    = 1'b0;
   localparam logic            MODE_TICK    = 1'b1;
   localparam logic [1:0]      CSR_SPARE_2  = 2'd2;
   localparam logic [1:0]      CSR_SPARE_3  = 2'd3;
   localparam int              RANDOM_ITEMS = 1120;
   localparam int              PHASE_ITEMS  = RANDOM_ITEMS / 8;

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_SUM,
      FRAME_BAD_DIGIT,
      FRAME_BAD_END,
      FRAME_CUT
   } frame_flaw_type;

   typedef struct {
      event_type              ev;
      logic [TAG_WIDTH-1:0]   tag;
      logic                   present;
      logic [COUNT_WIDTH-1:0] count;
   } reader_status_type;

   // DUT connections
   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_mode    = 1'b0;
   logic [7:0]                 req_rx_byte = 8'h00;
   logic                       rsp_stall   = 1'b0;
   logic                       csr_valid   = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index   = '0;
   logic [CFG_WIDTH-1:0]       csr_wdata   = '0;
   logic                       req_stall;
   logic                       rsp_valid;
   logic [1:0]                 rsp_event_code;
   logic [TAG_WIDTH-1:0]       rsp_tag_id;
   logic                       rsp_tag_present;
   logic [COUNT_WIDTH-1:0]     rsp_read_count;
   logic                       csr_ready;

   // Predicted receiver state
   logic [CFG_WIDTH-1:0]   dup_window    = DUP_WINDOW_RESET;
   logic [CFG_WIDTH-1:0]   hold_ticks    = PRESENCE_HOLD_RESET;
   logic [7:0]             frame_bytes [14];
   int                     frame_pos     = 0;
   logic [TAG_WIDTH-1:0]   last_tag      = '0;
   logic                   tag_seen      = 1'b0;
   logic [TW-1:0]          elapsed       = ELAPSED_MAX;
   logic                   present       = 1'b0;
   logic [COUNT_WIDTH-1:0] reads         = '0;

   reader_status_type      expected_status [$];
   reader_status_type      oldest_status;
   logic [TAG_WIDTH-1:0]   tag_pool [4];

   int idle_pct   = 0;
   int stall_pct  = 0;
   int items_sent = 0;
   int checked    = 0;
   int failures   = 0;
   int n_accepted = 0;
   int n_dup      = 0;
   int n_invalid  = 0;

   always #4 clock = ~clock;

   rfid_ascii_frame_receiver uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_code  (rsp_event_code),
      .rsp_tag_id      (rsp_tag_id),
      .rsp_tag_present (rsp_tag_present),
      .rsp_read_count  (rsp_read_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // ASCII hex digit to nibble; returns 0 for anything else
   function automatic logic ascii_to_nibble(input logic [7:0] c, output logic [3:0] v);
      v = c[3:0];
      if (c >= 8'h30 && c <= 8'h39) return 1'b1;
      v = c[3:0] + 4'd9;
      if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) return 1'b1;
      v = 4'd0;
      return 1'b0;
   endfunction

   // Nibble to ASCII, letters in random case
   function automatic logic [7:0] nibble_to_ascii(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return (($urandom_range(1, 0) != 0) ? 8'h41 : 8'h61) + 8'(n - 4'd10);
   endfunction

   function automatic logic [TAG_WIDTH-1:0] random_tag();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[TAG_WIDTH-1:0];
   endfunction

   // Check the gathered frame; gives the tag when framing, digits and checksum hold
   function automatic logic decode_frame(output logic [TAG_WIDTH-1:0] tag);
      logic [3:0] nib [12];
      logic [7:0] sum;
      int         i;
      tag = '0;
      if (frame_bytes[0] != START_BYTE || frame_bytes[13] != END_BYTE) return 1'b0;
      for (i = 0; i < 12; i++) begin
         if (!ascii_to_nibble(frame_bytes[1 + i], nib[i])) return 1'b0;
      end
      sum = 8'h00;
      for (i = 0; i < 10; i += 2) sum ^= {nib[i], nib[i + 1]};
      if (sum != {nib[10], nib[11]}) return 1'b0;
      for (i = 0; i < 10; i++) tag = {tag[TAG_WIDTH-5:0], nib[i]};
      return 1'b1;
   endfunction

   // Advance the predicted state by one item and queue the status it yields
   task automatic predict_status(input logic m, input logic [7:0] b);
      reader_status_type    s;
      logic [TAG_WIDTH-1:0] tag;
      event_type            ev;
      ev = EV_NONE;
      if (m == MODE_TICK) begin
         if (elapsed != ELAPSED_MAX) elapsed++;
      end else begin
         if (b == START_BYTE) frame_pos = 0;
         if (frame_pos >= FRAME_LEN) frame_pos = 0;
         frame_bytes[frame_pos] = b;
         frame_pos++;
         if (frame_pos == FRAME_LEN) begin
            if (decode_frame(tag)) begin
               if (tag_seen && tag == last_tag && elapsed < dup_window) begin
                  present = 1'b1;
                  ev      = EV_DUPLICATE;
               end else begin
                  last_tag = tag;
                  tag_seen = 1'b1;
                  elapsed  = '0;
                  reads++;
                  present  = 1'b1;
                  ev       = EV_ACCEPTED;
               end
            end else begin
               ev = EV_INVALID;
            end
            frame_pos = 0;
         end
      end
      // presence times out on every step, including a just-suppressed repeat
      if (present && elapsed > hold_ticks) present = 1'b0;
      s.ev      = ev;
      s.tag     = last_tag;
      s.present = present;
      s.count   = reads;
      expected_status = {expected_status, s};
   endtask

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99, 0) < stall_pct);
   end

   // Status checker: each rsp transfer against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status.size() == 0) begin
            $error("status transfer with nothing expected");
            failures++;
         end else begin
            oldest_status = expected_status.pop_front();
            checked++;
            case (oldest_status.ev)
               EV_ACCEPTED:  n_accepted++;
               EV_DUPLICATE: n_dup++;
               EV_INVALID:   n_invalid++;
               default: ;
            endcase
            if (rsp_event_code !== oldest_status.ev) begin
               $error("event_code: expected %0d, got %0d", oldest_status.ev, rsp_event_code);
               failures++;
            end
            if (rsp_tag_id !== oldest_status.tag) begin
               $error("tag_id: expected %h, got %h", oldest_status.tag, rsp_tag_id);
               failures++;
            end
            if (rsp_tag_present !== oldest_status.present) begin
               $error("tag_present: expected %0d, got %0d",
                      oldest_status.present, rsp_tag_present);
               failures++;
            end
            if (rsp_read_count !== oldest_status.count) begin
               $error("read_count: expected %0d, got %0d", oldest_status.count, rsp_read_count);
               failures++;
            end
         end
      end
   end

   // One req transfer, after random sender gaps
   task automatic send_item(input logic m, input logic [7:0] b);
      while ($urandom_range(99, 0) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= m;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      predict_status(m, b);
      items_sent++;
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_item(MODE_TICK, 8'($urandom_range(255, 0)));
   endtask

   // Build a frame for a tag, optionally damaged, and send it byte by byte
   task automatic send_frame(input logic [TAG_WIDTH-1:0] tag, input frame_flaw_type flaw);
      logic [7:0] fb [14];
      logic [7:0] sum;
      logic [3:0] dummy;
      int         i;
      int         len;
      int         pos;
      fb[0] = START_BYTE;
      for (i = 0; i < 10; i++) fb[1 + i] = nibble_to_ascii(tag[TAG_WIDTH-1-4*i -: 4]);
      sum    = tag[39:32] ^ tag[31:24] ^ tag[23:16] ^ tag[15:8] ^ tag[7:0];
      fb[11] = nibble_to_ascii(sum[7:4]);
      fb[12] = nibble_to_ascii(sum[3:0]);
      fb[13] = END_BYTE;
      len    = 14;
      case (flaw)
         FRAME_BAD_SUM: begin
            fb[12] = nibble_to_ascii(sum[3:0] ^ 4'($urandom_range(15, 1)));
         end
         FRAME_BAD_DIGIT: begin
            pos = $urandom_range(12, 1);
            do fb[pos] = 8'($urandom_range(255, 0)); while (ascii_to_nibble(fb[pos], dummy));
         end
         FRAME_BAD_END: begin
            do fb[13] = 8'($urandom_range(255, 0)); while (fb[13] == END_BYTE);
         end
         FRAME_CUT: len = $urandom_range(13, 1);
         default: ;
      endcase
      for (i = 0; i < len; i++) begin
         // a tick may land anywhere inside a frame
         if ($urandom_range(99, 0) < 4) send_ticks(1);
         send_item(MODE_BYTE, fb[i]);
      end
   endtask

   // Sender pauses until every predicted status has come out
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CFG_WIDTH-1:0] data, input logic last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_DUP_WINDOW) dup_window = data;
      else if (idx == CSR_PRESENCE_HOLD) hold_ticks = data;
      if (last) csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [CFG_WIDTH-1:0] win, input logic [CFG_WIDTH-1:0] hold);
      write_csr(CSR_DUP_WINDOW, win, 1'b0);
      write_csr(CSR_PRESENCE_HOLD, hold, 1'b1);
   endtask

   // Defaults after reset: saturated timer tick, stray bytes, zero tag, repeat
   task automatic test_reset_and_framing();
      send_item(MODE_TICK, 8'hFF);
      send_item(MODE_BYTE, 8'h00);
      send_item(MODE_BYTE, 8'hFF);
      send_frame('0, FRAME_GOOD);
      send_frame('0, FRAME_GOOD);
      drain_results();
   endtask

   // Zero hold time: presence drops on the first tick, a repeat cannot raise it
   task automatic test_presence_hold();
      configure(16'd5, 16'd0);
      send_frame('1, FRAME_GOOD);
      send_ticks(1);
      send_frame('1, FRAME_GOOD);
      drain_results();
   endtask

   // Maximum window: a repeat stays suppressed well after the first read
   task automatic test_wide_window();
      logic [TAG_WIDTH-1:0] tag;
      tag = random_tag();
      configure(16'hFFFF, 16'hFFFE);
      send_frame(tag, FRAME_GOOD);
      send_ticks(40);
      send_frame(tag, FRAME_GOOD);
      send_ticks(2);
      send_frame(tag, FRAME_GOOD);
      drain_results();
   endtask

   // Writes to the spare indexes must leave both windows alone
   task automatic test_spare_registers();
      write_csr(CSR_SPARE_2, 16'($urandom_range(65535, 0)), 1'b0);
      write_csr(CSR_SPARE_3, 16'($urandom_range(65535, 0)), 1'b0);
      write_csr(CSR_DUP_WINDOW, 16'd3, 1'b0);
      write_csr(CSR_PRESENCE_HOLD, 16'd4, 1'b0);
      write_csr(CSR_SPARE_2, 16'hFFFF, 1'b0);
      write_csr(CSR_SPARE_3, 16'h0000, 1'b1);
      tag_pool[0] = random_tag();
      send_frame(tag_pool[0], FRAME_GOOD);
      send_ticks(2);
      send_frame(tag_pool[0], FRAME_GOOD);
      send_ticks(3);
      send_frame(tag_pool[0], FRAME_GOOD);
      drain_results();
   endtask

   // One random slice of traffic: mostly frames, some damaged, noise and ticks
   task automatic random_step();
      int r;
      r = $urandom_range(99, 0);
      if (r < 50) begin
         send_frame(($urandom_range(99, 0) < 75) ? tag_pool[$urandom_range(3, 0)]
                                                  : random_tag(), FRAME_GOOD);
      end else if (r < 68) begin
         send_frame(random_tag(), frame_flaw_type'($urandom_range(4, 1)));
      end else if (r < 80) begin
         repeat ($urandom_range(16, 1)) send_item(MODE_BYTE, 8'($urandom_range(255, 0)));
      end else begin
         send_ticks($urandom_range(60, 1));
      end
   endtask

   // Phases of random traffic over window settings and idle and stall patterns
   task automatic test_random_traffic();
      int                   phase;
      int                   phase_start;
      logic                 paused;
      logic [CFG_WIDTH-1:0] win;
      logic [CFG_WIDTH-1:0] hold;
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      tag_pool[2] = random_tag();
      tag_pool[3] = random_tag();
      phase = 0;
      while (phase < 8) begin
         drain_results();
         case (phase % 8)
            0: begin win = 16'd0;            hold = 16'd0;               end
            1: begin win = 16'hFFFF;         hold = 16'hFFFF;            end
            2: begin win = 16'd1;            hold = 16'd1;               end
            3: begin win = DUP_WINDOW_RESET; hold = PRESENCE_HOLD_RESET; end
            default: begin
               win  = 16'($urandom_range(40, 0));
               hold = 16'($urandom_range(60, 0));
            end
         endcase
         configure(win, hold);
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 65; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 65; end
            default: begin idle_pct = 34; stall_pct = 34; end
         endcase
         phase_start = items_sent;
         paused      = 1'b0;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            random_step();
            if (!paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
               drain_results();
               paused = 1'b1;
            end
         end
         phase++;
      end
      idle_pct  = 0;
      stall_pct = 0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_and_framing();
      test_presence_hold();
      test_wide_window();
      test_spare_registers();
      test_random_traffic();
      drain_results();
      repeat (16) @(posedge clock);
      $display("Sent %0d items and checked %0d status transfers over 8 window settings",
               items_sent, checked);
      $display("Tag reads: %0d accepted, %0d suppressed repeats, %0d bad frames",
               n_accepted, n_dup, n_invalid);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/rfar_pkg.sv
hw/rtl/rfar_front.sv
hw/rtl/rfar_queue.sv
hw/rtl/rfar_back.sv
hw/rtl/rfid_ascii_frame_receiver.sv
hw/rtl/rfar_checker.sv
tb/sv/rfid_ascii_frame_receiver_tb.sv
